@@ rtl/core/weighted_window_filter_with_metrics_top_defines.svh @@
// Assertion macros for the weighted window filter checker.
`ifndef WEIGHTED_WINDOW_FILTER_WITH_METRICS_TOP_DEFINES_SVH
`define WEIGHTED_WINDOW_FILTER_WITH_METRICS_TOP_DEFINES_SVH

// same-cycle implication
`define WWFM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WWFM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/wwfm_pkg.sv @@
// Shared types, constants and helpers for the weighted window filter.
package wwfm_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 16;
  localparam int H_W         = 9;
  localparam int NUM_COEF    = 5;
  localparam int PROD_W      = SAMPLE_W + COEF_W + 1;
  localparam int ACC_W       = PROD_W + 3;
  localparam int ADDR_W      = 5;
  localparam int REG_IDX_W   = 3;
  localparam int SCORE_P_W   = H_W + SAMPLE_W;

  localparam logic [REG_IDX_W-1:0] REG_WEIGHT_H = 3'd5;

  localparam logic [COEF_W-1:0] COEF_RESET [NUM_COEF] = '{
    16'd21845, 16'd21845, 16'd21845, 16'd0, 16'd0
  };
  localparam logic [H_W-1:0] WEIGHT_H_RESET = 9'd128;
  localparam logic [H_W-1:0] WEIGHT_H_ONE   = 9'd256;

  typedef struct packed {
    logic shift;
    logic clear;
    logic load;
    logic pass;
  } cell_ctrl_t;

  typedef struct packed {
    logic update;
    logic score;
    logic clear;
  } met_ctrl_t;

  // round half up, dropping the 16 fraction bits of the Q0.16 taps, and saturate to 16 bits
  function automatic logic signed [SAMPLE_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] biased;
    logic signed [ACC_W-1:0] shifted;
    begin
      biased  = acc + ACC_W'(32768);
      shifted = biased >>> 16;
      if (shifted > ACC_W'(32767)) begin
        round_sat = 16'sh7FFF;
      end else if (shifted < -ACC_W'(32768)) begin
        round_sat = 16'sh8000;
      end else begin
        round_sat = shifted[SAMPLE_W-1:0];
      end
    end
  endfunction

  function automatic logic [SAMPLE_W-1:0] abs_diff(input logic signed [SAMPLE_W-1:0] a,
                                                   input logic signed [SAMPLE_W-1:0] b);
    logic signed [SAMPLE_W:0] d;
    logic signed [SAMPLE_W:0] m;
    begin
      d = {a[SAMPLE_W-1], a} - {b[SAMPLE_W-1], b};
      m = d[SAMPLE_W] ? -d : d;
      abs_diff = m[SAMPLE_W-1:0];
    end
  endfunction

endpackage

@@ rtl/core/wwfm_tap_cell.sv @@
// One window tap: holds a sample, forms its weighted product, shifts both along the chain.
module wwfm_tap_cell (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  wwfm_pkg::cell_ctrl_t                  ctrl,
  input  logic [wwfm_pkg::COEF_W-1:0]           coef,
  input  logic signed [wwfm_pkg::SAMPLE_W-1:0]  sample_in,
  input  logic signed [wwfm_pkg::PROD_W-1:0]    prod_in,
  output logic signed [wwfm_pkg::SAMPLE_W-1:0]  sample_out,
  output logic signed [wwfm_pkg::PROD_W-1:0]    prod_out
);
  import wwfm_pkg::*;

  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [SAMPLE_W-1:0] sample_nxt;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [PROD_W-1:0]   prod_nxt;

  always_comb begin
    sample_nxt = sample_r;
    if (ctrl.clear) begin
      sample_nxt = '0;
    end else if (ctrl.shift) begin
      sample_nxt = sample_in;
    end
  end

  always_comb begin
    prod_nxt = prod_r;
    if (ctrl.load) begin
      prod_nxt = PROD_W'(sample_r) * PROD_W'($signed({1'b0, coef}));
    end else if (ctrl.pass) begin
      prod_nxt = prod_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
    end else begin
      sample_r <= sample_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign sample_out = sample_r;
  assign prod_out   = prod_r;

endmodule

@@ rtl/core/wwfm_metrics.sv @@
// Frame metrics: running step and gap maxima plus the blended score.
module wwfm_metrics (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  wwfm_pkg::met_ctrl_t                   ctrl,
  input  logic [wwfm_pkg::H_W-1:0]              weight_h,
  input  logic signed [wwfm_pkg::SAMPLE_W-1:0]  y,
  input  logic signed [wwfm_pkg::SAMPLE_W-1:0]  center,
  output logic [wwfm_pkg::SAMPLE_W-1:0]         noisiness,
  output logic [wwfm_pkg::SAMPLE_W-1:0]         deviation,
  output logic [wwfm_pkg::SAMPLE_W-1:0]         combined,
  output logic [wwfm_pkg::SAMPLE_W-1:0]         score
);
  import wwfm_pkg::*;

  logic signed [SAMPLE_W-1:0] prev_r;
  logic signed [SAMPLE_W-1:0] prev_nxt;
  logic                       have_prev_r;
  logic                       have_prev_nxt;
  logic [SAMPLE_W-1:0]        noise_r;
  logic [SAMPLE_W-1:0]        noise_nxt;
  logic [SAMPLE_W-1:0]        dev_r;
  logic [SAMPLE_W-1:0]        dev_nxt;
  logic [SCORE_P_W-1:0]       pn_r;
  logic [SCORE_P_W-1:0]       pd_r;
  logic [H_W-1:0]             h_eff;
  logic [H_W-1:0]             h_inv;
  logic [SAMPLE_W-1:0]        step;
  logic [SAMPLE_W-1:0]        gap;
  logic [SCORE_P_W:0]         score_sum;

  assign step  = abs_diff(y, prev_r);
  assign gap   = abs_diff(y, center);
  assign h_eff = (weight_h > WEIGHT_H_ONE) ? WEIGHT_H_ONE : weight_h;
  assign h_inv = WEIGHT_H_ONE - h_eff;

  always_comb begin
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    noise_nxt     = noise_r;
    dev_nxt       = dev_r;
    if (ctrl.clear) begin
      prev_nxt      = '0;
      have_prev_nxt = 1'b0;
      noise_nxt     = '0;
      dev_nxt       = '0;
    end else if (ctrl.update) begin
      if (have_prev_r && (step > noise_r)) begin
        noise_nxt = step;
      end
      if (gap > dev_r) begin
        dev_nxt = gap;
      end
      prev_nxt      = y;
      have_prev_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      noise_r     <= '0;
      dev_r       <= '0;
    end else begin
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
      noise_r     <= noise_nxt;
      dev_r       <= dev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.score) begin
      pn_r <= SCORE_P_W'(h_eff) * SCORE_P_W'(noise_r);
      pd_r <= SCORE_P_W'(h_inv) * SCORE_P_W'(dev_r);
    end
  end

  assign score_sum = {1'b0, pn_r} + {1'b0, pd_r} + (SCORE_P_W+1)'(128);
  assign score     = (|score_sum[SCORE_P_W:SAMPLE_W+8]) ? '1 : score_sum[SAMPLE_W+7:8];
  assign noisiness = noise_r;
  assign deviation = dev_r;
  assign combined  = (noise_r > dev_r) ? noise_r : dev_r;

endmodule

@@ rtl/core/weighted_window_filter_with_metrics_top.sv @@
// Weighted window filter top: config registers, tap cell chain, sequencer, result register.
// Items are taken one at a time: in_stall stays high until the sequencer is idle again.
// The products drain one cell per cycle through the chain into a single accumulator.
// An item yields a result only once the window is full or when it closes a frame.
// A stalled result holds the sequencer in its final step until taken.
// Reset (rst_n low, synchronous): window, fill count, metric maxima cleared; taps and h to defaults.
module weighted_window_filter_with_metrics_top #(
  parameter int HALF_WIDTH = 1
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [wwfm_pkg::ADDR_W-1:0]           paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [wwfm_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                                  in_frame_last,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [wwfm_pkg::SAMPLE_W-1:0]  out_filtered,
  output logic [wwfm_pkg::SAMPLE_W-1:0]         out_noisiness,
  output logic [wwfm_pkg::SAMPLE_W-1:0]         out_deviation,
  output logic [wwfm_pkg::SAMPLE_W-1:0]         out_combined,
  output logic [wwfm_pkg::SAMPLE_W-1:0]         out_weighted_score,
  output logic                                  out_frame_end
);
  import wwfm_pkg::*;

  // half width held to 1..2
  localparam int HW_EFF = (HALF_WIDTH < 1) ? 1 : ((HALF_WIDTH > 2) ? 2 : HALF_WIDTH);
  localparam int NTAPS  = 2 * HW_EFF + 1;
  localparam int FILL_W = $clog2(NTAPS + 1);
  localparam int CNT_W  = $clog2(NTAPS);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MUL   = 7'b0000010,
    ST_ACC   = 7'b0000100,
    ST_RND   = 7'b0001000,
    ST_MET   = 7'b0010000,
    ST_SCORE = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [COEF_W-1:0]         coef_r [NUM_COEF];
  logic [H_W-1:0]            weight_h_r;
  logic [FILL_W-1:0]         fill_r, fill_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [SAMPLE_W-1:0] y_r, y_nxt;
  logic                      produced_r, produced_nxt;
  logic                      last_r, last_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_load;
  logic                      accept;
  logic                      cfg_we;
  logic [REG_IDX_W-1:0]      reg_idx;
  cell_ctrl_t                cell_ctrl;
  met_ctrl_t                 met_ctrl;
  logic signed [SAMPLE_W-1:0] samp_w [NTAPS];
  logic signed [PROD_W-1:0]   prod_w [NTAPS];
  logic [SAMPLE_W-1:0]       met_noise, met_dev, met_comb, met_score;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_COEF; k++) begin
        coef_r[k] <= COEF_RESET[k];
      end
      weight_h_r <= WEIGHT_H_RESET;
    end else if (cfg_we) begin
      for (int k = 0; k < NUM_COEF; k++) begin
        if (reg_idx == REG_IDX_W'(k)) begin
          coef_r[k] <= pwdata[COEF_W-1:0];
        end
      end
      if (reg_idx == REG_WEIGHT_H) begin
        weight_h_r <= pwdata[H_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    for (int k = 0; k < NUM_COEF; k++) begin
      if (reg_idx == REG_IDX_W'(k)) begin
        prdata = {{(32-COEF_W){1'b0}}, coef_r[k]};
      end
    end
    if (reg_idx == REG_WEIGHT_H) begin
      prdata = {{(32-H_W){1'b0}}, weight_h_r};
    end
  end

  // tap cell chain, oldest sample in cell 0
  for (genvar k = 0; k < NTAPS; k++) begin : g_cell
    logic signed [SAMPLE_W-1:0] s_in;
    logic signed [PROD_W-1:0]   p_in;
    if (k == NTAPS - 1) begin : g_end
      assign s_in = in_sample;
      assign p_in = '0;
    end else begin : g_mid
      assign s_in = samp_w[k+1];
      assign p_in = prod_w[k+1];
    end
    wwfm_tap_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (cell_ctrl),
      .coef       (coef_r[k]),
      .sample_in  (s_in),
      .prod_in    (p_in),
      .sample_out (samp_w[k]),
      .prod_out   (prod_w[k])
    );
  end

  wwfm_metrics u_metrics (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (met_ctrl),
    .weight_h  (weight_h_r),
    .y         (y_r),
    .center    (samp_w[HW_EFF]),
    .noisiness (met_noise),
    .deviation (met_dev),
    .combined  (met_comb),
    .score     (met_score)
  );

  // sequencer
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    y_nxt         = y_r;
    produced_nxt  = produced_r;
    last_nxt      = last_r;
    cell_ctrl     = '0;
    met_ctrl      = '0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cell_ctrl.shift = 1'b1;
          last_nxt        = in_frame_last;
          if (fill_r < FILL_W'(NTAPS)) begin
            fill_nxt = fill_r + 1'b1;
          end
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cell_ctrl.load = 1'b1;
        acc_nxt        = '0;
        cnt_nxt        = '0;
        state_nxt      = ST_ACC;
      end
      ST_ACC: begin
        cell_ctrl.pass = 1'b1;
        acc_nxt = acc_r + {{(ACC_W-PROD_W){prod_w[0][PROD_W-1]}}, prod_w[0]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NTAPS - 1)) begin
          state_nxt = ST_RND;
        end
      end
      ST_RND: begin
        produced_nxt = (fill_r == FILL_W'(NTAPS));
        y_nxt        = (fill_r == FILL_W'(NTAPS)) ? round_sat(acc_r) : '0;
        state_nxt    = ST_MET;
      end
      ST_MET: begin
        met_ctrl.update = produced_r;
        state_nxt = (produced_r || last_r) ? ST_SCORE : ST_IDLE;
      end
      ST_SCORE: begin
        met_ctrl.score = 1'b1;
        state_nxt      = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          if (last_r) begin
            cell_ctrl.clear = 1'b1;
            met_ctrl.clear  = 1'b1;
            fill_nxt        = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    acc_r      <= acc_nxt;
    y_r        <= y_nxt;
    produced_r <= produced_nxt;
    last_r     <= last_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_filtered       <= y_r;
      out_noisiness      <= met_noise;
      out_deviation      <= met_dev;
      out_combined       <= met_comb;
      out_weighted_score <= met_score;
      out_frame_end      <= last_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/core/wwfm_checker.sv @@
// Port-level assertions for the weighted window filter, bound to the top level.
`include "weighted_window_filter_with_metrics_top_defines.svh"

module wwfm_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [wwfm_pkg::SAMPLE_W-1:0]  out_filtered,
  input logic [wwfm_pkg::SAMPLE_W-1:0]         out_noisiness,
  input logic [wwfm_pkg::SAMPLE_W-1:0]         out_deviation,
  input logic [wwfm_pkg::SAMPLE_W-1:0]         out_combined,
  input logic [wwfm_pkg::SAMPLE_W-1:0]         out_weighted_score
);

  `WWFM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_filtered), "stalled item dropped or changed")

  `WWFM_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "second item accepted while busy")

  `WWFM_ASSERT_NOW(a_comb_max, out_valid, (out_combined >= out_noisiness) && (out_combined >= out_deviation) && ((out_combined == out_noisiness) || (out_combined == out_deviation)), "combined is not the larger metric")

  `WWFM_ASSERT_NOW(a_score_bound, out_valid, out_weighted_score <= out_combined, "score exceeds larger metric")

endmodule

bind weighted_window_filter_with_metrics_top wwfm_checker u_wwfm_checker (.*);

@@ tb/tb_weighted_window_filter_with_metrics_top.sv @@
// Self-checking testbench for the weighted window filter: APB tap setup, sample frames, metric checks.
`timescale 1ns / 100ps

module tb_weighted_window_filter_with_metrics_top;

  localparam int HALF_W       = 1;
  localparam int TAPS         = 2 * HALF_W + 1;
  localparam int DRAIN_CYCLES = 2 * HALF_W + 12;
  localparam int CYCLE_LIMIT  = 250000;
  localparam int REPORT_LIMIT = 10;
  localparam int HOLD_CYCLES  = 150;
  localparam int PADDR_W      = wwfm_pkg::ADDR_W;
  localparam int REG_COEF_0   = 0;
  localparam int REG_H        = wwfm_pkg::REG_WEIGHT_H;
  localparam int REG_SPARE    = REG_H + 1;

  typedef struct packed {
    logic signed [15:0] filtered;
    logic [15:0]        noisiness;
    logic [15:0]        deviation;
    logic [15:0]        combined;
    logic [15:0]        score;
    logic               frame_end;
  } filter_result_t;

  class filter_scoreboard;
    logic [15:0]        coef [5];
    logic [8:0]         blend_h;
    logic signed [15:0] window [5];
    int                 fill;
    logic signed [15:0] prev_out;
    bit                 have_prev;
    logic [15:0]        noise_max;
    logic [15:0]        dev_max;
    filter_result_t     pending [$];
    int                 mismatches;
    int                 samples_noted;
    int                 results_checked;
    int                 frames_closed;

    function new();
      coef    = '{16'd21845, 16'd21845, 16'd21845, 16'd0, 16'd0};
      blend_h = 9'd128;
      clear_frame();
    endfunction

    function void clear_frame();
      foreach (window[k]) window[k] = '0;
      fill      = 0;
      prev_out  = '0;
      have_prev = 0;
      noise_max = '0;
      dev_max   = '0;
    endfunction

    function void write_reg(int idx, logic [31:0] value);
      if (idx >= REG_COEF_0 && idx < REG_COEF_0 + 5) begin
        coef[idx - REG_COEF_0] = value[15:0];
      end else if (idx == REG_H) begin
        blend_h = value[8:0];
      end
    endfunction

    function logic [15:0] gap(logic signed [15:0] a, logic signed [15:0] b);
      int d;
      d = int'(a) - int'(b);
      if (d < 0) d = -d;
      return d[15:0];
    endfunction

    function void note_sample(logic signed [15:0] s, logic last);
      longint             acc;
      longint             r;
      longint             ws;
      int                 h;
      logic signed [15:0] y;
      logic [15:0]        st;
      logic [15:0]        dv;
      bit                 produced;
      filter_result_t     res;
      y        = '0;
      produced = 0;
      samples_noted++;
      for (int k = 0; k < TAPS - 1; k++) window[k] = window[k + 1];
      window[TAPS - 1] = s;
      if (fill < TAPS) fill++;
      if (fill >= TAPS) begin
        acc = 0;
        for (int k = 0; k < TAPS; k++) acc += longint'(window[k]) * longint'(coef[k]);
        r = (acc + 32768) >>> 16;
        if (r > 32767) r = 32767;
        else if (r < -32768) r = -32768;
        y        = r[15:0];
        produced = 1;
        if (have_prev) begin
          st = gap(y, prev_out);
          if (st > noise_max) noise_max = st;
        end
        dv = gap(y, window[HALF_W]);
        if (dv > dev_max) dev_max = dv;
        prev_out  = y;
        have_prev = 1;
      end
      if (!produced && !last) return;
      h  = (blend_h > 256) ? 256 : int'(blend_h);
      ws = (longint'(h) * noise_max + longint'(256 - h) * dev_max + 128) >> 8;
      if (ws > 65535) ws = 65535;
      res.filtered  = y;
      res.noisiness = noise_max;
      res.deviation = dev_max;
      res.combined  = (noise_max > dev_max) ? noise_max : dev_max;
      res.score     = ws[15:0];
      res.frame_end = last;
      pending = {pending, res};
      if (last) clear_frame();
    endfunction

    function void check_result(filter_result_t got);
      filter_result_t want;
      results_checked++;
      if (got.frame_end) frames_closed++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: unexpected result filtered=%0d frame_end=%0b",
                   $time, got.filtered, got.frame_end);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("%0t: mismatch (expected/actual) filtered %0d/%0d noisiness %0d/%0d",
                   $time, want.filtered, got.filtered, want.noisiness, got.noisiness);
          $display("  deviation %0d/%0d combined %0d/%0d score %0d/%0d frame_end %0b/%0b",
                   want.deviation, got.deviation, want.combined, got.combined,
                   want.score, got.score, want.frame_end, got.frame_end);
        end
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] in_sample;
  logic               in_frame_last;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] out_filtered;
  logic [15:0]        out_noisiness;
  logic [15:0]        out_deviation;
  logic [15:0]        out_combined;
  logic [15:0]        out_weighted_score;
  logic               out_frame_end;

  filter_scoreboard sb;
  bit               idle_on;
  bit               hold_req;
  int               settings_used;
  int               cycle_count;

  weighted_window_filter_with_metrics_top #(
    .HALF_WIDTH(HALF_W)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample         (in_sample),
    .in_frame_last     (in_frame_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_filtered      (out_filtered),
    .out_noisiness     (out_noisiness),
    .out_deviation     (out_deviation),
    .out_combined      (out_combined),
    .out_weighted_score(out_weighted_score),
    .out_frame_end     (out_frame_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic apb_write(input int idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * idx);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_filter(input logic [15:0] c0, input logic [15:0] c1,
                            input logic [15:0] c2, input logic [15:0] c3,
                            input logic [15:0] c4, input logic [8:0] h);
    apb_write(REG_COEF_0 + 0, 32'(c0));
    apb_write(REG_COEF_0 + 1, 32'(c1));
    apb_write(REG_COEF_0 + 2, 32'(c2));
    apb_write(REG_COEF_0 + 3, 32'(c3));
    apb_write(REG_COEF_0 + 4, 32'(c4));
    apb_write(REG_H, 32'(h));
    settings_used++;
  endtask

  // valid stays high between back-to-back items; this task lowers it only while idling
  task automatic send_item(input logic signed [15:0] s, input logic last);
    while (idle_on && $urandom_range(0, 99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_sample     <= s;
    in_frame_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(s, last);
  endtask

  function automatic logic signed [15:0] pick_sample(input logic signed [15:0] prev);
    int mode;
    mode = $urandom_range(0, 99);
    if (mode < 55) return 16'($urandom);
    if (mode < 80) return 16'(int'(prev) + int'($urandom_range(0, 2000)) - 1000);
    case ($urandom_range(0, 3))
      0: begin
        return 16'sh7FFF;
      end
      1: begin
        return 16'sh8000;
      end
      2: begin
        return 16'sh0000;
      end
      default: begin
        return 16'shFFFF;
      end
    endcase
  endfunction

  task automatic send_frame(input int len);
    logic signed [15:0] s;
    s = 16'($urandom);
    for (int i = 0; i < len; i++) begin
      s = pick_sample(s);
      send_item(s, i == len - 1);
    end
  endtask

  task automatic run_frames(input int target, input bit with_hold);
    int sent;
    int len;
    int r;
    int pause_at;
    sent     = 0;
    pause_at = target / 2;
    if (with_hold) hold_req = 1'b1;
    while (sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 12) len = $urandom_range(1, 2);
      else if (r < 88) len = $urandom_range(3, 12);
      else len = $urandom_range(20, 40);
      send_frame(len);
      sent += len;
      if (pause_at > 0 && sent >= pause_at) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        pause_at = 0;
      end
    end
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // result side: sample at the edge, then decide the next stall
  initial begin
    int             hold_left;
    filter_result_t got;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got = '{out_filtered, out_noisiness, out_deviation, out_combined,
                out_weighted_score, out_frame_end};
        sb.check_result(got);
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idle_on && ($urandom_range(0, 99) < 37);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, sb.pending.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic signed [15:0] sweep [8];
    sweep = '{16'shFFFF, 16'sh0000, 16'sh0001, 16'sh8000,
              16'sh7FFF, 16'sh5555, 16'shAAAA, 16'sh0007};
    sb            = new();
    idle_on       = 1'b1;
    rst_n         <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    in_valid      <= 1'b0;
    in_sample     <= '0;
    in_frame_last <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset taps: one-, two- and three-sample frames, then a sweep of corner values
    send_item(16'sh7FFF, 1'b1);
    send_item(16'sh8000, 1'b0);
    send_item(16'sh0000, 1'b1);
    send_item(16'sh7FFF, 1'b0);
    send_item(16'sh8000, 1'b0);
    send_item(16'sh7FFF, 1'b1);
    for (int i = 0; i < 8; i++) send_item(sweep[i], i == 7);
    in_valid <= 1'b0;
    wait_drained();

    // full-scale taps, h at one: both saturation directions
    set_filter(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 9'd256);
    apb_write(REG_SPARE, 32'hFFFF_FFFF);
    for (int i = 0; i < 4; i++) send_item(16'sh7FFF, i == 3);
    for (int i = 0; i < 4; i++) send_item(16'sh8000, i == 3);
    run_frames(110, 1'b0);
    wait_drained();

    set_filter(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 9'd0);
    run_frames(60, 1'b0);
    wait_drained();

    // no idling here; output held off at the start to back up the input
    idle_on = 1'b0;
    set_filter(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom), 9'($urandom_range(0, 256)));
    run_frames(120, 1'b1);
    wait_drained();
    idle_on = 1'b1;

    set_filter(16'($urandom_range(10000, 30000)), 16'($urandom_range(10000, 30000)),
               16'($urandom_range(10000, 30000)), 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 65535)), 9'($urandom_range(0, 256)));
    run_frames(130, 1'b0);
    wait_drained();

    $display("Checked %0d results (%0d frame ends) from %0d samples over %0d tap settings;",
             sb.results_checked, sb.frames_closed, sb.samples_noted, settings_used + 1);
    $display("short frames, saturation, zero taps and a long output hold were exercised.");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ weighted_window_filter_with_metrics_top.f @@
+incdir+rtl/core
rtl/core/wwfm_pkg.sv
rtl/core/wwfm_tap_cell.sv
rtl/core/wwfm_metrics.sv
rtl/core/weighted_window_filter_with_metrics_top.sv
rtl/core/wwfm_checker.sv
tb/tb_weighted_window_filter_with_metrics_top.sv
